// ===== hw/rtl/histogram_edge_rebinner_macros.svh =====
// Assertion macros used by the rebinner checker.
`ifndef HISTOGRAM_EDGE_REBINNER_MACROS_SVH
`define HISTOGRAM_EDGE_REBINNER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HER_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define HER_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/her_pkg.sv =====
// Types, codes and constants of the histogram edge rebinner.
package her_pkg;

    localparam int MAX_NEW_EDGES_DEF = 64;
    localparam int EDGE_WIDTH_DEF    = 32;

    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 48;
    localparam int STATUS_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

    // word index of each register, taken from paddr[2]
    localparam logic REG_NEW_EDGE_COUNT = 1'b0;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INNER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTER = 2'd2;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'b001,
        PH_ACC     = 3'b010,
        PH_SWALLOW = 3'b100
    } her_phase_t;

    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        edge_index;
        logic signed [VALUE_W-1:0] edge_value;
        logic signed [VALUE_W-1:0] bin_content;
        logic                      last_edge;
    } her_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]      new_bin_index;
        logic signed [SUM_W-1:0] bin_sum;
        logic [STATUS_W-1:0]     status;
        logic                    last_result;
    } her_out_t;

endpackage

// ===== hw/rtl/her_table.sv =====
// New edge table with one write port, one read port and registered read data.
module her_table
    import her_pkg::*;
#(
    parameter int DEPTH = MAX_NEW_EDGES_DEF,
    parameter int WIDTH = EDGE_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_NEW_EDGES_DEF)
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [WIDTH-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic signed [WIDTH-1:0] rdata
);

    logic signed [WIDTH-1:0] mem [DEPTH];
    logic signed [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/her_core.sv =====
// Compare and accumulate stage, stream state and result register.
module her_core
    import her_pkg::*;
#(
    parameter int MAX_NEW_EDGES = MAX_NEW_EDGES_DEF,
    parameter int EDGE_WIDTH    = EDGE_WIDTH_DEF,
    parameter int AW            = $clog2(MAX_NEW_EDGES_DEF)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [COUNT_W-1:0]           new_edge_count,
    input  logic                         take,
    input  logic signed [EDGE_WIDTH-1:0] take_key,
    input  logic signed [VALUE_W-1:0]    take_content,
    input  logic                         take_last,
    input  logic signed [EDGE_WIDTH-1:0] table_edge,
    output logic                         can_take,
    output logic [AW-1:0]                read_index,
    output logic                         result_valid,
    input  logic                         result_stall,
    output her_out_t                     result
);

    localparam int FW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam logic [FW-1:0] MAX_F = FW'(MAX_NEW_EDGES);
    localparam logic [FW-1:0] TWO_F = FW'(2);
    localparam logic [FW-1:0] ONE_F = FW'(1);

    logic                         s1_valid_reg, s1_valid_next;
    logic signed [EDGE_WIDTH-1:0] s1_key_reg;
    logic signed [SUM_W-1:0]      s1_content_reg;
    logic                         s1_last_reg;

    her_phase_t              phase_reg, phase_next;
    logic [AW-1:0]           target_reg, target_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic     res_valid_reg, res_valid_next;
    her_out_t res_reg, res_next;

    logic          fire;
    logic          emit;
    logic          is_lt;
    logic          is_gt;
    logic [FW-1:0] cnt_ext;
    logic [FW-1:0] cnt_eff;
    logic [FW-1:0] final_index;
    logic          at_final;
    logic [AW-1:0] target_dec;

    assign fire     = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign can_take = !s1_valid_reg || fire;

    assign is_lt = s1_key_reg < table_edge;
    assign is_gt = s1_key_reg > table_edge;

    // clamp the register into 2..MAX_NEW_EDGES
    assign cnt_ext     = FW'(new_edge_count);
    assign cnt_eff     = (cnt_ext < TWO_F) ? TWO_F :
                         ((cnt_ext > MAX_F) ? MAX_F : cnt_ext);
    assign final_index = cnt_eff - ONE_F;
    assign at_final    = FW'(target_reg) >= final_index;
    assign target_dec  = target_reg - AW'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        sum_next    = sum_reg;
        emit        = 1'b0;
        res_next    = '0;

        case (phase_reg)
            PH_SEARCH:
            begin
                if (is_lt)
                begin
                    if (s1_last_reg)
                    begin
                        emit               = 1'b1;
                        res_next.status    = STATUS_OUTER;
                        res_next.last_result = 1'b1;
                        phase_next         = PH_SEARCH;
                    end
                end
                else if (is_gt)
                begin
                    emit                 = 1'b1;
                    res_next.status      = STATUS_INNER;
                    res_next.last_result = 1'b1;
                    phase_next           = s1_last_reg ? PH_SEARCH : PH_SWALLOW;
                end
                else if (s1_last_reg)
                begin
                    emit                 = 1'b1;
                    res_next.status      = STATUS_OUTER;
                    res_next.last_result = 1'b1;
                    phase_next           = PH_SEARCH;
                end
                else
                begin
                    phase_next  = PH_ACC;
                    target_next = AW'(1);
                    sum_next    = s1_content_reg;
                end
            end
            PH_ACC:
            begin
                if (is_lt)
                begin
                    if (s1_last_reg)
                    begin
                        emit                 = 1'b1;
                        res_next.status      = STATUS_OUTER;
                        res_next.last_result = 1'b1;
                        phase_next           = PH_SEARCH;
                    end
                    else
                    begin
                        sum_next = sum_reg + s1_content_reg;
                    end
                end
                else if (is_gt)
                begin
                    emit                 = 1'b1;
                    res_next.status      = STATUS_INNER;
                    res_next.last_result = 1'b1;
                    phase_next           = s1_last_reg ? PH_SEARCH : PH_SWALLOW;
                end
                else if (at_final)
                begin
                    // closing edge of the final new bin
                    emit                   = 1'b1;
                    res_next.new_bin_index = INDEX_W'(target_dec);
                    res_next.bin_sum       = sum_reg;
                    res_next.status        = STATUS_OK;
                    res_next.last_result   = 1'b1;
                    phase_next             = s1_last_reg ? PH_SEARCH : PH_SWALLOW;
                end
                else if (s1_last_reg)
                begin
                    emit                 = 1'b1;
                    res_next.status      = STATUS_OUTER;
                    res_next.last_result = 1'b1;
                    phase_next           = PH_SEARCH;
                end
                else
                begin
                    // inner edge: close this bin, open the next one
                    emit                   = 1'b1;
                    res_next.new_bin_index = INDEX_W'(target_dec);
                    res_next.bin_sum       = sum_reg;
                    res_next.status        = STATUS_OK;
                    target_next            = target_reg + AW'(1);
                    sum_next               = s1_content_reg;
                end
            end
            default:
            begin
                phase_next = s1_last_reg ? PH_SEARCH : PH_SWALLOW;
            end
        endcase

        // back to the start of a stream: drop target and sum
        if (phase_next == PH_SEARCH)
        begin
            target_next = '0;
            sum_next    = '0;
        end
    end

    // address for the request entering this cycle follows the updated target
    assign read_index = fire ? target_next : target_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (fire && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_SEARCH;
            target_reg    <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                phase_reg  <= phase_next;
                target_reg <= target_next;
                sum_reg    <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_key_reg     <= take_key;
            s1_content_reg <= SUM_W'(take_content);
            s1_last_reg    <= take_last;
        end
        if (fire && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hw/rtl/histogram_edge_rebinner.sv =====
// Histogram edge rebinner: top level with APB register, edge table and core.
//
// Rebins a histogram onto coarser, aligned edges. A request with kind 0
// writes one new edge into the table; a request with kind 1 streams one old
// edge (ascending) with the content of the old bin that starts there, and
// last_edge marks the final old edge. Old bins before the first new edge or
// after the last one are dropped; the others are summed into their new bin,
// and a result goes out when an old edge hits the next new edge exactly.
// A new edge missing among the old edges gives status 1, old edges running
// out too early give status 2; after an error or the final bin the block
// swallows requests up to the last edge. The block takes one request per
// cycle while the compare stage can advance: the edge table has one write
// and one read port and serves either the write of a load or the read of a
// data request in each cycle, and the read address for the next data
// request is the target edge as updated by the request in the compare
// stage. An accepted data request is registered into the compare stage
// together with its table read, compare and accumulate land in the result
// register; a held result stalls the compare stage, not the input, until
// one request is waiting. new_edge_count (byte address 0)
// holds the number of valid table entries and resets to 2; write it and the
// table only while no request is in flight. The table has no reset; every
// entry that a stream reaches must be loaded first.
module histogram_edge_rebinner
    import her_pkg::*;
#(
    parameter int MAX_NEW_EDGES = MAX_NEW_EDGES_DEF,
    parameter int EDGE_WIDTH    = EDGE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input requests
    input  logic                  item_valid,
    output logic                  item_stall,
    input  her_in_t               item,
    // results
    output logic                  result_valid,
    input  logic                  result_stall,
    output her_out_t              result,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = (MAX_NEW_EDGES > 1) ? $clog2(MAX_NEW_EDGES) : 1;

    logic [COUNT_W-1:0] count_reg, count_next;

    logic                         accept;
    logic                         take;
    logic                         load_we;
    logic                         can_take;
    logic [63:0]                  edge_wide;
    logic signed [EDGE_WIDTH-1:0] edge_key;
    logic [AW-1:0]                read_index;
    logic signed [EDGE_WIDTH-1:0] table_edge;

    // register port: no wait states, one register in word 0
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(count_reg);

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_NEW_EDGE_COUNT))
        begin
            count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the input whenever the compare stage is full and cannot advance.
    assign item_stall = !can_take;
    assign accept     = item_valid && !item_stall;
    assign take       = accept && (item.kind == KIND_DATA);

    // Drop loads whose index lies beyond the table.
    assign load_we = accept && (item.kind == KIND_LOAD) &&
                     ({26'b0, item.edge_index} < 32'(MAX_NEW_EDGES));

    // Sign-extend, then keep the table width; signed order is kept for EDGE_WIDTH from 32 to 64.
    assign edge_wide = {{32{item.edge_value[31]}}, item.edge_value};
    assign edge_key  = edge_wide[EDGE_WIDTH-1:0];

    her_table #(
        .DEPTH (MAX_NEW_EDGES),
        .WIDTH (EDGE_WIDTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(item.edge_index)),
        .wdata (edge_key),
        .re    (take),
        .raddr (read_index),
        .rdata (table_edge)
    );

    her_core #(
        .MAX_NEW_EDGES (MAX_NEW_EDGES),
        .EDGE_WIDTH    (EDGE_WIDTH),
        .AW            (AW)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .new_edge_count (count_reg),
        .take           (take),
        .take_key       (edge_key),
        .take_content   (item.bin_content),
        .take_last      (item.last_edge),
        .table_edge     (table_edge),
        .can_take       (can_take),
        .read_index     (read_index),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result)
    );

endmodule

// ===== hw/rtl/her_checker.sv =====
// Port-level checker for the histogram edge rebinner, bound to the top level.
`include "histogram_edge_rebinner_macros.svh"

module her_checker
    import her_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     item_valid,
    input logic     item_stall,
    input logic     result_valid,
    input logic     result_stall,
    input her_out_t result
);

    `HER_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    `HER_ASSERT_NOW(a_error_is_last, clk, rst_n, result_valid && (result.status != STATUS_OK), result.last_result, "error result without last_result")

    `HER_ASSERT_NOW(a_error_zero, clk, rst_n, result_valid && (result.status != STATUS_OK), (result.bin_sum == '0) && (result.new_bin_index == '0), "error result carries data")

    `HER_ASSERT_NOW(a_result_cause, clk, rst_n, result_valid && !$past(result_valid), $past(item_valid && !item_stall, 2), "result without an earlier request")

endmodule

bind histogram_edge_rebinner her_checker u_her_checker (.*);

// ===== tb/sv/tb_histogram_edge_rebinner.sv =====
// Self-checking testbench for the histogram edge rebinner: directed and random bin streams.
module tb_histogram_edge_rebinner;
    timeunit 1ns;
    timeprecision 1ps;

    import her_pkg::*;

    localparam longint EDGE_MIN  = -64'sd2147483648;
    localparam longint EDGE_MAX  = 64'sd2147483647;
    localparam longint NEAR_SPAN = 64'sd1048576;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     RANDOM_REQUESTS = 600;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    her_in_t               item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    her_out_t              result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    histogram_edge_rebinner dut (.*);

    // ------------------------------------------------------------------
    // Predicted state of the rebinner: edge table, count register, the
    // open new bin and the stream phase. Updated once per accepted request.
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] edge_table_model [MAX_NEW_EDGES_DEF];
    logic [COUNT_W-1:0]        edge_count_reg = COUNT_RESET;
    int                        target_edge = 0;
    logic signed [SUM_W-1:0]   open_sum = '0;
    her_phase_t                rebin_phase = PH_SEARCH;

    her_out_t pending_bins [$];     // completed bins still to come out, oldest first
    int       mismatch_cnt = 0;
    int       sent_items = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b1;

    function automatic void restart_search();
        rebin_phase = PH_SEARCH;
        target_edge = 0;
        open_sum    = '0;
    endfunction

    // Queue one result; close the stream on the last edge, else swallow to it.
    function automatic void post_bin(int idx, logic signed [SUM_W-1:0] sum,
                                     logic [STATUS_W-1:0] st, bit ends);
        pending_bins.push_back(her_out_t'{INDEX_W'(idx), sum, st, 1'b1});
        if (ends)
            restart_search();
        else
            rebin_phase = PH_SWALLOW;
    endfunction

    function automatic void rebin_predict(her_in_t r);
        int                        cnt;
        int                        t;
        logic signed [SUM_W-1:0]   content;
        logic signed [VALUE_W-1:0] edge_now;
        logic signed [VALUE_W-1:0] target_val;
        if (r.kind == KIND_LOAD)
        begin
            edge_table_model[r.edge_index] = r.edge_value;
            return;
        end
        edge_now = r.edge_value;
        content  = {{(SUM_W-VALUE_W){r.bin_content[VALUE_W-1]}}, r.bin_content};
        // out-of-range counts act as the nearest legal one
        cnt = edge_count_reg;
        if (cnt < 2)
            cnt = 2;
        if (cnt > MAX_NEW_EDGES_DEF)
            cnt = MAX_NEW_EDGES_DEF;
        case (rebin_phase)
            PH_ACC:
            begin
                t = target_edge;
                if (t < 1 || t >= MAX_NEW_EDGES_DEF)
                    t = 1;
                target_val = edge_table_model[t];
                if (edge_now < target_val)
                begin
                    // inside the open bin: add, unless the stream ends here
                    if (r.last_edge)
                        post_bin(0, '0, STATUS_OUTER, 1'b1);
                    else
                        open_sum = open_sum + content;
                end
                else if (edge_now > target_val)
                    post_bin(0, '0, STATUS_INNER, r.last_edge);
                else if (t >= cnt - 1)
                    // final new edge matched; a target past a shrunk count lands here too
                    post_bin(t - 1, open_sum, STATUS_OK, r.last_edge);
                else if (r.last_edge)
                    post_bin(0, '0, STATUS_OUTER, 1'b1);
                else
                begin
                    pending_bins.push_back(her_out_t'{INDEX_W'(t - 1), open_sum,
                                                      STATUS_OK, 1'b0});
                    target_edge = t + 1;
                    open_sum    = content;
                end
            end
            PH_SEARCH:
            begin
                target_val = edge_table_model[0];
                if (edge_now < target_val)
                begin
                    // drop bins in front of the first new edge
                    if (r.last_edge)
                        post_bin(0, '0, STATUS_OUTER, 1'b1);
                end
                else if (edge_now > target_val)
                    post_bin(0, '0, STATUS_INNER, r.last_edge);
                else if (r.last_edge)
                    post_bin(0, '0, STATUS_OUTER, 1'b1);
                else
                begin
                    rebin_phase = PH_ACC;
                    target_edge = 1;
                    open_sum    = content;
                end
            end
            default:
                if (r.last_edge)
                    restart_search();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall on a pattern picked at random (none, light, half,
    // heavy) for a run of random length, compare each accepted result.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(3, 0);
            stall_left = $urandom_range(300, 50);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(3, 0) == 0);
            2:       result_stall <= ($urandom_range(1, 0) == 0);
            default: result_stall <= ($urandom_range(15, 0) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        her_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_bins.size() == 0)
            begin
                $error("unexpected result: new_bin_index %0d bin_sum %0d status %0d",
                       result.new_bin_index, $signed(result.bin_sum), result.status);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_bins.pop_front();
                if (result.new_bin_index !== want.new_bin_index)
                begin
                    $error("new_bin_index: expected %0d, got %0d",
                           want.new_bin_index, result.new_bin_index);
                    mismatch_cnt++;
                end
                if (result.bin_sum !== want.bin_sum)
                begin
                    $error("bin_sum: expected %0d, got %0d",
                           $signed(want.bin_sum), $signed(result.bin_sum));
                    mismatch_cnt++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_cnt++;
                end
                if (result.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, result.last_result);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drive one request at the falling edge and hold it until accepted.
    // With gaps on, requests go out in bursts of random length.
    task automatic send_request(input her_in_t r);
        if (gaps_on && burst_left == 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat ($urandom_range(5, 0)) @(negedge clk);
            burst_left = $urandom_range(24, 1);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= r;
        do @(posedge clk); while (item_stall);
        rebin_predict(r);
        sent_items++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_load(input int idx, input longint value);
        her_in_t r;
        r.kind        = KIND_LOAD;
        r.edge_index  = INDEX_W'(idx);
        r.edge_value  = VALUE_W'(value);
        r.bin_content = $urandom;              // don't care on a load
        r.last_edge   = $urandom_range(1, 0);
        send_request(r);
    endtask

    task automatic send_data(input longint value, input logic [VALUE_W-1:0] content,
                             input bit last);
        her_in_t r;
        r.kind        = KIND_DATA;
        r.edge_index  = INDEX_W'($urandom);    // don't care on old edges
        r.edge_value  = VALUE_W'(value);
        r.bin_content = content;
        r.last_edge   = last;
        send_request(r);
    endtask

    // Stream a run of old edges with random contents; closes marks the last one.
    task automatic send_edges(input longint vals [$], input bit closes);
        int i;
        for (i = 0; i < vals.size(); i++)
            send_data(vals[i], $urandom, closes && (i == vals.size() - 1));
    endtask

    // Pause the sender until every expected result is out, then let the
    // pipeline run dry so the table and register may be touched.
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write new_edge_count (setup then access phase) and read it back.
    task automatic write_edge_count(input logic [COUNT_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'({REG_NEW_EDGE_COUNT, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        edge_count_reg = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[COUNT_W-1:0] !== value)
        begin
            $error("new_edge_count readback: expected %0d, got %0d", value, rd[COUNT_W-1:0]);
            mismatch_cnt++;
        end
    endtask

    // Random value strictly between lo and hi; needs hi - lo > 1.
    function automatic longint pick_between(longint lo, longint hi);
        return lo + 1 + longint'($urandom) % (hi - lo - 1);
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Edges at both ends of the range, contents at both extremes; with the
    // reset count of 2 there is one new bin and its sum is -1.
    task automatic test_extreme_edges();
        send_load(0, EDGE_MIN);
        send_load(1, EDGE_MAX);
        send_data(EDGE_MIN, 32'h7fff_ffff, 1'b0);
        send_data(0, 32'h8000_0000, 1'b0);
        send_data(EDGE_MAX, $urandom, 1'b1);
    endtask

    // Counts below 2 behave as 2.
    task automatic test_count_clamp();
        int i;
        for (i = 0; i < 2; i++)
        begin
            settle();
            write_edge_count(COUNT_W'(i));
            send_edges({EDGE_MIN, EDGE_MAX}, 1'b1);
        end
    endtask

    // Four new edges at 10..40: a clean stream and each error path.
    task automatic test_bin_streams();
        int i;
        settle();
        write_edge_count(7'd4);
        for (i = 0; i < 4; i++)
            send_load(i, 10 * (i + 1));
        // drop a bin in front, close three bins, swallow the edge behind
        send_edges({5, 10, 15, 20, 25, 30, 35, 40, 50}, 1'b1);
        // new edge 20 missing: inner error, swallow to the last edge
        send_edges({10, 25, 40}, 1'b1);
        // stream ends on an inner new edge: outer error, bin lost
        send_edges({10, 20}, 1'b1);
        // stream ends before the first new edge
        send_edges({5}, 1'b1);
        // first old edge already past the first new edge
        send_edges({12, 40}, 1'b1);
    endtask

    // Change count and table while a stream is open: bin 1 becomes final
    // and its closing edge moves from 30 to 25.
    task automatic test_midstream_changes();
        send_edges({10, 20}, 1'b0);
        settle();
        write_edge_count(7'd3);
        send_load(2, 25);
        settle();
        send_edges({25, 40}, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random streams: mostly well-formed with random content, the rest
    // skipped edges, early ends, wrong starts and plain noise.
    // ------------------------------------------------------------------
    task automatic test_random_streams();
        longint fe [MAX_NEW_EDGES_DEF];
        longint v;
        int     eff, sel, skip_k, cut_k, n, i, k, start, filled;
        int     scale;
        bit     tail, first;
        first  = 1'b1;
        filled = 4;                 // entries 0..3 hold edges from the directed part
        start  = sent_items;
        while (sent_items - start < RANDOM_REQUESTS)
        begin
            settle();
            gaps_on = ($urandom_range(2, 0) != 0);
            // first stream uses the largest table through an oversized count
            if (first)
                write_edge_count(7'd127);
            else if ($urandom_range(1, 0) == 0)
            begin
                case ($urandom_range(9, 0))
                    0:       write_edge_count(COUNT_W'($urandom_range(1, 0)));
                    1:       write_edge_count(COUNT_W'($urandom_range(127, 65)));
                    2:       write_edge_count(COUNT_W'($urandom_range(64, 7)));
                    default: write_edge_count(COUNT_W'($urandom_range(6, 2)));
                endcase
            end
            eff = edge_count_reg;
            if (eff < 2)
                eff = 2;
            if (eff > MAX_NEW_EDGES_DEF)
                eff = MAX_NEW_EDGES_DEF;

            // reload the table whenever the count reaches past written entries, else at random
            if (eff > filled || $urandom_range(1, 0) == 0)
            begin
                scale = $urandom_range(2, 0);
                v = ($urandom_range(7, 0) == 0) ? EDGE_MIN : longint'($signed($urandom)) / 2;
                for (i = 0; i < eff; i++)
                begin
                    if (i > 0)
                        case (scale)
                            0:       v = v + $urandom_range(4, 1);
                            1:       v = v + $urandom_range(1000, 1);
                            default: v = v + $urandom_range(1 << 24, 1);
                        endcase
                    if (i == eff - 1 && $urandom_range(7, 0) == 0)
                        v = EDGE_MAX;
                    send_load(i, v);
                end
                if (eff > filled)
                    filled = eff;
            end
            for (i = 0; i < eff; i++)
                fe[i] = longint'(edge_table_model[i]);

            sel    = $urandom_range(9, 0);
            skip_k = (sel == 6) ? $urandom_range(eff - 1, 1) : 0;
            cut_k  = (sel == 7) ? $urandom_range(eff - 1, 1) : 0;
            tail   = (sel == 6) || ($urandom_range(2, 0) == 0);
            first  = 1'b0;

            if (sel == 8)
            begin
                // noise: values at random or next to table edges, scattered last edges
                n = $urandom_range(8, 3);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(1, 0) == 0)
                        v = longint'($signed($urandom));
                    else
                        v = fe[$urandom_range(eff - 1, 0)] + longint'($urandom_range(4, 0)) - 2;
                    if (v < EDGE_MIN)
                        v = EDGE_MIN;
                    if (v > EDGE_MAX)
                        v = EDGE_MAX;
                    send_data(v, $urandom, (i == n - 1) || ($urandom_range(5, 0) == 0));
                end
                continue;
            end

            // a few dropped bins in front of the first new edge
            v = (fe[0] - NEAR_SPAN < EDGE_MIN) ? EDGE_MIN - 1 : fe[0] - NEAR_SPAN;
            repeat ($urandom_range(2, 0))
                if (fe[0] - v > 1)
                begin
                    v = pick_between(v, fe[0]);
                    send_data(v, $urandom, 1'b0);
                end
            // wrong start: first old edge beyond the first new edge
            send_data((sel == 9) ? fe[0] + 1 : fe[0], $urandom, 1'b0);
            v = fe[0];

            for (k = 1; k < eff; k++)
            begin
                repeat ($urandom_range(3, 0))
                    if (fe[k] - v > 1)
                    begin
                        v = pick_between(v, fe[k]);
                        send_data(v, $urandom, 1'b0);
                    end
                if (k == cut_k)
                begin
                    // end early, on the new edge or short of it
                    if ($urandom_range(1, 0) == 0 || fe[k] - v < 2)
                        send_data(fe[k], $urandom, 1'b1);
                    else
                        send_data(pick_between(v, fe[k]), $urandom, 1'b1);
                    break;
                end
                // skipped edge: step just past the new edge instead of onto it
                v = (k == skip_k && fe[k] < EDGE_MAX) ? fe[k] + 1 : fe[k];
                send_data(v, $urandom, (k == eff - 1) && !tail);
            end

            // swallowed edges behind the final new edge, the last one closes
            if (cut_k == 0 && tail)
            begin
                n = $urandom_range(2, 1);
                for (i = 0; i < n; i++)
                begin
                    if (v < EDGE_MAX)
                        v = pick_between(v, EDGE_MAX + 1);
                    send_data(v, $urandom, i == n - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extreme_edges();
        test_count_clamp();
        test_bin_streams();
        test_midstream_changes();
        test_random_streams();
        settle();

        if (mismatch_cnt == 0 && pending_bins.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
